// ===== rtl/corridor_pt_limiter_assert.svh =====
// assertion macros for the corridor pT limiter
`ifndef CORRIDOR_PT_LIMITER_ASSERT_SVH
`define CORRIDOR_PT_LIMITER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define CPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("corridor_pt_limiter check failed");
// next-cycle implication
`define CPL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("corridor_pt_limiter check failed");
`else
`define CPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CPL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/cpl_pkg.sv =====
package cpl_pkg;

    // opcodes of an input word
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int PT_W    = 12;
    localparam int CUT_W   = 13;
    localparam int SCALE_W = 24;
    localparam int PROD_W  = PT_W + SCALE_W;
    localparam int FRAC_W  = 20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_HYP,
        S_WALK,
        S_DONE
    } t_state;

    // table port controls
    typedef struct packed {
        logic                    we;
        logic                    re;
        logic signed [CUT_W-1:0] wdata;
    } t_mem_cmd;

    // one result word
    typedef struct packed {
        logic [PT_W-1:0] refined_pt;
        logic            was_limited;
    } t_res;

endpackage

// ===== rtl/cpl_table.sv =====
module cpl_table #(
    parameter int DEPTH = 306,
    parameter int AW    = 9
) (
    input  logic                  i_clk,
    input  cpl_pkg::t_mem_cmd     i_cmd,
    input  logic [AW-1:0]         i_waddr,
    input  logic [AW-1:0]         i_raddr,
    output logic signed [12:0]    o_rdata
);
    import cpl_pkg::*;

    logic signed [CUT_W-1:0] mem [DEPTH];
    logic signed [CUT_W-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_waddr] <= i_cmd.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cpl_seq.sv =====
module cpl_seq #(
    parameter int NUM_BINS      = 32,
    parameter int NUM_CORRIDORS = 9,
    parameter int AW            = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [3:0]           i_corridor_select,
    input  logic [5:0]           i_entry_bin,
    input  logic signed [12:0]   i_entry_cut,
    input  logic [11:0]          i_pt_hypothesis,
    input  logic signed [12:0]   i_measured_value,
    input  logic [23:0]          i_bin_scale,
    output cpl_pkg::t_mem_cmd    o_mem_cmd,
    output logic [AW-1:0]        o_mem_waddr,
    output logic [AW-1:0]        o_mem_raddr,
    input  logic signed [12:0]   i_mem_rdata,
    output logic                 o_res_valid,
    output cpl_pkg::t_res        o_res,
    input  logic                 i_res_take
);
    import cpl_pkg::*;

    localparam int BPT  = NUM_BINS + 2;
    localparam int BINW = $clog2(BPT);

    t_state              r_state, n_state;
    logic [PT_W-1:0]     r_pt;
    logic [CUT_W-1:0]    r_mag;
    logic [AW-1:0]       r_base;
    logic [PROD_W-1:0]   r_prod;
    logic [BINW-1:0]     r_p, n_p;
    t_res                r_res, n_res;

    logic                accept;
    logic                sel_ok;
    logic                bin_ok;
    logic [31:0]         base32;
    logic [31:0]         waddr32;
    logic [CUT_W-1:0]    mv_bits;
    logic [CUT_W-1:0]    mag_in;
    logic [15:0]         scaled;
    logic [BINW-1:0]     hyp_bin;
    logic                cut_def;
    logic [CUT_W-1:0]    cut_u;
    logic                hyp_limit;
    logic                walk_hit;
    logic [BINW-1:0]     fin_limit;
    logic [31:0]         fin_sh;
    t_res                fin_res;

    // input decode
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign sel_ok     = 32'(i_corridor_select) < 32'(NUM_CORRIDORS);
    assign bin_ok     = 32'(i_entry_bin) < 32'(BPT);
    assign base32     = 32'(i_corridor_select) * 32'(BPT);
    assign waddr32    = base32 + 32'(i_entry_bin);
    assign mv_bits    = i_measured_value;
    assign mag_in     = mv_bits[CUT_W-1] ? (~mv_bits + 13'd1) : mv_bits;

    // hypothesis bin, clamped to the top bin
    assign scaled  = r_prod[PROD_W-1:FRAC_W];
    assign hyp_bin = (scaled >= 16'(NUM_BINS)) ? BINW'(NUM_BINS + 1)
                                               : (scaled[BINW-1:0] + BINW'(1));

    // cut compare against the word read last cycle
    assign cut_def   = !i_mem_rdata[CUT_W-1];
    assign cut_u     = {1'b0, i_mem_rdata[CUT_W-2:0]};
    assign hyp_limit = cut_def && (r_mag > cut_u);
    assign walk_hit  = cut_def && (r_mag < cut_u);

    // limit bin: the bin that hit during the walk, else the floor bin
    assign fin_limit = (r_state == S_WALK && walk_hit) ? r_p : BINW'(1);

    // final result from the chosen limit bin
    assign fin_sh              = 32'(fin_limit) << 4;
    assign fin_res.was_limited = fin_sh < 32'(r_pt);
    assign fin_res.refined_pt  = fin_res.was_limited ? fin_sh[PT_W-1:0] : r_pt;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pt   <= i_pt_hypothesis;
            r_mag  <= mag_in;
            r_base <= base32[AW-1:0];
            r_prod <= PROD_W'(i_pt_hypothesis) * PROD_W'(i_bin_scale);
        end
        r_p   <= n_p;
        r_res <= n_res;
    end

    // next state, table accesses and result staging
    always_comb begin
        n_state         = r_state;
        n_p             = r_p;
        n_res           = r_res;
        o_mem_cmd.we    = 1'b0;
        o_mem_cmd.re    = 1'b0;
        o_mem_cmd.wdata = i_entry_cut;
        o_mem_waddr     = waddr32[AW-1:0];
        o_mem_raddr     = r_base + AW'(r_p - BINW'(1));
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_LOAD) begin
                        o_mem_cmd.we = sel_ok && bin_ok;
                        n_res        = '0;
                        n_state      = S_DONE;
                    end else if (!sel_ok) begin
                        n_res.refined_pt  = i_pt_hypothesis;
                        n_res.was_limited = 1'b0;
                        n_state           = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_p          = hyp_bin;
                o_mem_cmd.re = 1'b1;
                o_mem_raddr  = r_base + AW'(hyp_bin);
                n_state      = S_HYP;
            end
            S_HYP: begin
                if (!hyp_limit) begin
                    n_res.refined_pt  = r_pt;
                    n_res.was_limited = 1'b0;
                    n_state           = S_DONE;
                end else if (r_p == BINW'(1)) begin
                    n_res   = fin_res;
                    n_state = S_DONE;
                end else begin
                    n_p          = r_p - BINW'(1);
                    o_mem_cmd.re = 1'b1;
                    n_state      = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_hit) begin
                    n_res   = fin_res;
                    n_state = S_DONE;
                end else if (r_p == BINW'(1)) begin
                    n_res   = fin_res;
                    n_state = S_DONE;
                end else begin
                    n_p          = r_p - BINW'(1);
                    o_mem_cmd.re = 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// ===== rtl/corridor_pt_limiter.sv =====
// Corridor pT limiter. Load words (opcode 0) write one cut into a corridor table and
// return a zero word on the output. Query words (opcode 1) scale the pT hypothesis into
// a bin, read that bin's cut and, when the measured magnitude exceeds a defined cut, walk
// down the table one entry per cycle until a bin with a larger defined cut is found or
// bin 1 is reached. The table memory has a single read port, and only one word is in
// flight at a time. The table holds no reset value: every bin a query can touch must be
// loaded first. bin_scale may only be written while no word is in flight.
`include "corridor_pt_limiter_assert.svh"

module corridor_pt_limiter #(
    parameter int NUM_BINS      = 32,
    parameter int NUM_CORRIDORS = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [23:0]          i_cfg_bin_scale,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [3:0]           i_corridor_select,
    input  logic [5:0]           i_entry_bin,
    input  logic signed [12:0]   i_entry_cut,
    input  logic [11:0]          i_pt_hypothesis,
    input  logic signed [12:0]   i_measured_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [11:0]          o_refined_pt,
    output logic                 o_was_limited
);
    import cpl_pkg::*;

    localparam int BPT   = NUM_BINS + 2;
    localparam int DEPTH = NUM_CORRIDORS * BPT;
    localparam int AW    = $clog2(DEPTH);

    logic [SCALE_W-1:0]       r_bin_scale;
    logic                     r_out_valid;
    t_res                     r_out;
    t_mem_cmd                 mem_cmd;
    logic [AW-1:0]            mem_waddr;
    logic [AW-1:0]            mem_raddr;
    logic signed [CUT_W-1:0]  mem_rdata;
    logic                     res_valid;
    t_res                     res;
    logic                     res_take;
    logic                     in_take;

    assign in_take = i_in_valid && o_in_ready;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_scale <= SCALE_W'(65536);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bin_scale <= i_cfg_bin_scale;
        end
    end

    // sequencer
    cpl_seq #(
        .NUM_BINS      (NUM_BINS),
        .NUM_CORRIDORS (NUM_CORRIDORS),
        .AW            (AW)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_corridor_select (i_corridor_select),
        .i_entry_bin       (i_entry_bin),
        .i_entry_cut       (i_entry_cut),
        .i_pt_hypothesis   (i_pt_hypothesis),
        .i_measured_value  (i_measured_value),
        .i_bin_scale       (r_bin_scale),
        .o_mem_cmd         (mem_cmd),
        .o_mem_waddr       (mem_waddr),
        .o_mem_raddr       (mem_raddr),
        .i_mem_rdata       (mem_rdata),
        .o_res_valid       (res_valid),
        .o_res             (res),
        .i_res_take        (res_take)
    );

    // cut table memory
    cpl_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_waddr (mem_waddr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register
    assign res_take = res_valid && (!r_out_valid || i_out_ready);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_refined_pt  = r_out.refined_pt;
    assign o_was_limited = r_out.was_limited;

    // checks
    `CPL_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, in_take, !o_in_ready)
    `CPL_ASSERT_IMP(a_write_on_load, i_clk, i_rst_n, mem_cmd.we, in_take && i_opcode == OP_LOAD)
    `CPL_ASSERT_IMP(a_limit_floor, i_clk, i_rst_n, o_out_valid && o_was_limited, o_refined_pt >= 12'd16)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import cpl_pkg::*;

    localparam int N_TABLES      = 9;
    localparam int BINS          = 34;
    localparam int TOP_BIN       = BINS - 1;
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 40;

    logic                  i_clk;
    logic                  i_rst_n           = 1'b0;
    logic                  i_cfg_valid       = 1'b0;
    logic                  o_cfg_ready;
    logic [23:0]           i_cfg_bin_scale   = '0;
    logic                  i_in_valid        = 1'b0;
    logic                  o_in_ready;
    logic                  i_opcode          = OP_LOAD;
    logic [3:0]            i_corridor_select = '0;
    logic [5:0]            i_entry_bin       = '0;
    logic signed [12:0]    i_entry_cut       = '0;
    logic [11:0]           i_pt_hypothesis   = '0;
    logic signed [12:0]    i_measured_value  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready       = 1'b0;
    logic [11:0]           o_refined_pt;
    logic                  o_was_limited;

    // predictor state: cut tables and bin scale
    logic signed [12:0]    cut_tab [N_TABLES][BINS];
    logic [23:0]           scale_q16 = 24'd65536;
    t_res                  pending_results [$];

    int                    mismatches  = 0;
    int                    idle_cycles = 0;
    int                    gap_pct     = 6;
    int                    stall_pct   = 65;

    corridor_pt_limiter u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_bin_scale   (i_cfg_bin_scale),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_corridor_select (i_corridor_select),
        .i_entry_bin       (i_entry_bin),
        .i_entry_cut       (i_entry_cut),
        .i_pt_hypothesis   (i_pt_hypothesis),
        .i_measured_value  (i_measured_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_refined_pt      (o_refined_pt),
        .o_was_limited     (o_was_limited)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // expected result of one word; loads update the table copy
    function automatic t_res corridor_outcome(logic op, logic [3:0] sel, logic [5:0] ebin,
                                              logic signed [12:0] ecut, logic [11:0] pt,
                                              logic signed [12:0] meas);
        t_res        r;
        logic [35:0] prod;
        int          mag;
        int          hyp;
        int          bin;
        int          cut;
        int          limit;
        int          result;
        int          p;
        r = '0;
        if (op == OP_LOAD) begin
            if (sel < N_TABLES && ebin < BINS)
                cut_tab[sel][ebin] = ecut;
            return r;
        end
        // unknown table: pass the hypothesis through
        if (sel >= N_TABLES) begin
            r.refined_pt = pt;
            return r;
        end
        mag  = (meas < 0) ? -int'(meas) : int'(meas);
        prod = {24'b0, pt} * {12'b0, scale_q16};
        hyp  = int'(prod >> 20);
        bin  = (hyp + 1 > TOP_BIN) ? TOP_BIN : hyp + 1;
        result = int'(pt);
        cut    = int'(cut_tab[sel][bin]);
        // walk down to the first defined bin with a wider cut
        if (cut >= 0 && mag > cut) begin
            limit = 1;
            for (p = bin - 1; p > 0; p--) begin
                if (int'(cut_tab[sel][p]) >= 0 && mag < int'(cut_tab[sel][p])) begin
                    limit = p;
                    break;
                end
            end
            if ((limit << 4) < result)
                result = limit << 4;
        end
        r.refined_pt  = 12'(result);
        r.was_limited = (result < int'(pt));
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // send one word and record its expected result
    task automatic send_word(logic op, logic [3:0] sel, logic [5:0] ebin,
                             logic signed [12:0] ecut, logic [11:0] pt,
                             logic signed [12:0] meas);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_opcode          = op;
        i_corridor_select = sel;
        i_entry_bin       = ebin;
        i_entry_cut       = ecut;
        i_pt_hypothesis   = pt;
        i_measured_value  = meas;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(corridor_outcome(op, sel, ebin, ecut, pt, meas));
    endtask

    task automatic load_cut(logic [3:0] sel, logic [5:0] ebin, logic signed [12:0] ecut);
        send_word(OP_LOAD, sel, ebin, ecut, 12'($urandom), 13'($urandom));
    endtask

    task automatic ask_pt(logic [3:0] sel, logic [11:0] pt, logic signed [12:0] meas);
        send_word(OP_QUERY, sel, 6'($urandom), 13'($urandom), pt, meas);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // bin scale write, only with nothing in flight
    task automatic write_bin_scale(logic [23:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid     = 1'b1;
        i_cfg_bin_scale = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        scale_q16 = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic signed [12:0] random_cut();
        if ($urandom_range(99) < 25)
            return 13'(-int'($urandom_range(4096, 1)));
        return 13'($urandom_range(4095, 0));
    endfunction

    // one random word, mostly queries on loaded tables
    task automatic random_word();
        logic [3:0]         sel;
        logic [5:0]         ebin;
        logic [11:0]        pt;
        logic signed [12:0] meas;
        int                 m;
        if ($urandom_range(99) < 25) begin
            sel  = ($urandom_range(9) != 0) ? 4'($urandom_range(N_TABLES - 1)) :
                                              4'($urandom_range(15));
            ebin = ($urandom_range(9) != 0) ? 6'($urandom_range(TOP_BIN)) : 6'($urandom_range(63));
            load_cut(sel, ebin, random_cut());
        end else begin
            sel = ($urandom_range(99) < 92) ? 4'($urandom_range(N_TABLES - 1)) :
                                              4'($urandom_range(15));
            pt  = $urandom_range(1) ? 12'($urandom_range(BINS * 16)) : 12'($urandom);
            // large magnitudes push the walk all the way down
            if ($urandom_range(99) < 30) begin
                m    = $urandom_range(4096, 3800);
                meas = $urandom_range(1) ? 13'(-m) : 13'((m > 4095) ? 4095 : m);
            end else begin
                meas = 13'($urandom);
            end
            ask_pt(sel, pt, meas);
        end
    endtask

    // every entry of every table gets a cut
    task automatic test_table_fill();
        int t;
        int b;
        for (t = 0; t < N_TABLES; t++)
            for (b = 0; b < BINS; b++)
                load_cut(4'(t), 6'(b), random_cut());
    endtask

    // hand-picked corridor in table 0 at one bin per 16 pT counts, plus out-of-range tables and bins
    task automatic test_directed_cases();
        load_cut(4'd0, 6'd0, -13'sd4096);
        load_cut(4'd0, 6'd33, 13'sd4095);
        load_cut(4'd9, 6'd5, 13'sd100);
        load_cut(4'd15, 6'd63, 13'sd0);
        load_cut(4'd0, 6'd34, 13'sd0);
        load_cut(4'd0, 6'd63, -13'sd1);
        load_cut(4'd0, 6'd5, 13'sd100);
        load_cut(4'd0, 6'd4, -13'sd1);
        load_cut(4'd0, 6'd3, 13'sd50);
        load_cut(4'd0, 6'd2, 13'sd300);
        load_cut(4'd0, 6'd1, 13'sd10);
        ask_pt(4'd0, 12'd64, 13'sd150);
        ask_pt(4'd0, 12'd79, 13'sd150);
        ask_pt(4'd0, 12'd64, -13'sd100);
        ask_pt(4'd0, 12'd64, 13'sd0);
        ask_pt(4'd0, 12'd64, 13'sd300);
        ask_pt(4'd0, 12'd64, -13'sd4096);
        ask_pt(4'd0, 12'd48, 13'sd4095);
        ask_pt(4'd0, 12'd0, 13'sd20);
        ask_pt(4'd0, 12'd40, 13'sd60);
        ask_pt(4'd0, 12'd4095, -13'sd4096);
        ask_pt(4'd0, 12'd4095, 13'sd4095);
        ask_pt(4'd9, 12'd1234, -13'sd4096);
        ask_pt(4'd15, 12'd4095, 13'sd4095);
    endtask

    // bin scale extremes and a few settings between
    task automatic test_bin_scale_sweep();
        logic [23:0] scales [6];
        int          s;
        int          k;
        scales = '{24'd0, 24'hFFFFFF, 24'd1, 24'd98304, 24'($urandom), 24'd65536};
        for (s = 0; s < 6; s++) begin
            write_bin_scale(scales[s]);
            for (k = 0; k < 40; k++)
                random_word();
        end
    endtask

    task automatic test_random_traffic(int count);
        int k;
        for (k = 0; k < count; k++)
            random_word();
    endtask

    // output ready with random stalls
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= stall_pct);

    // result checker
    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("word with nothing pending, refined_pt", o_refined_pt, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_refined_pt !== want.refined_pt)
                    report_mismatch("refined_pt", o_refined_pt, want.refined_pt);
                if (o_was_limited !== want.was_limited)
                    report_mismatch("was_limited", o_was_limited, want.was_limited);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("corridor_pt_limiter verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // test sequence
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        gap_pct   = 6;
        stall_pct = 65;
        test_table_fill();
        test_directed_cases();
        test_random_traffic(400);

        gap_pct   = 65;
        stall_pct = 6;
        test_bin_scale_sweep();
        test_random_traffic(400);

        gap_pct   = 0;
        stall_pct = 0;
        write_bin_scale(24'($urandom_range(140000, 30000)));
        test_random_traffic(430);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("corridor_pt_limiter verification clean");
        else
            $display("corridor_pt_limiter verification failed");
        $finish;
    end

endmodule
